// ===== rtl/ced_pkg.sv =====
// shared types and constants for the 3x3 canny edge detector
// used by canny_edge_detector_3x3 and ced_sqrt; no dependencies
package ced_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 11;
  localparam int HGT_MAX    = 1024;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WGT_W      = 16;
  localparam int ACC_W      = 28;
  localparam int RAD_W      = 17;
  localparam int ROOT_W     = 8;
  localparam int NTAP       = 9;
  localparam int TAP_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_LOW_THRESH    = 3'd2,
    REG_HIGH_THRESH   = 3'd3,
    REG_WEIGHT_CENTER = 3'd4,
    REG_WEIGHT_SIDE   = 3'd5,
    REG_WEIGHT_CORNER = 3'd6
  } cfg_reg_e;

  localparam logic [1:0] DIR_0  = 2'd0;
  localparam logic [1:0] DIR_45 = 2'd1;
  localparam logic [1:0] DIR_90 = 2'd2;

  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_WEAK   = 2'd1;
  localparam logic [1:0] CLS_STRONG = 2'd2;

  localparam logic [TAP_W-1:0] TAP_CENTER = 4'd4;
  localparam logic [TAP_W-1:0] TAP_LAST   = 4'd8;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } ced_in_t;

  typedef struct packed {
    logic edge_res;
    logic last_of_frame;
  } ced_out_t;

  typedef struct packed {
    logic [PIX_W-1:0] raw;
    logic [PIX_W-1:0] blur;
    logic [PIX_W-1:0] mag;
    logic [1:0]       dir;
    logic [1:0]       cls;
  } ced_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RAW,
    S_STEP,
    S_CHECK,
    S_TAP,
    S_DRAIN,
    S_EVAL,
    S_GSQ,
    S_SQST,
    S_SQRT,
    S_GWB,
    S_ADV,
    S_DONE
  } ced_state_e;

endpackage

// ===== rtl/ced_sqrt.sv =====
// iterative integer square root, one result bit per cycle, capped at 255
// depends on ced_pkg
module ced_sqrt
  import ced_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0]    rad_q;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [ROOT_W-1:0]   mask_q;
  logic                busy_q;
  logic                done_q;
  logic [ROOT_W-1:0]   trial;
  logic [2*ROOT_W-1:0] trial_sq;

  assign trial    = root_q | mask_q;
  assign trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);
  assign root_d   = (RAD_W'(trial_sq) <= rad_q) ? trial : root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mask_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        mask_q <= {1'b1, {(ROOT_W-1){1'b0}}};
      end else if (busy_q) begin
        mask_q <= mask_q >> 1;
        if (mask_q[0]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
    end else if (busy_q) begin
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

  property p_done_after_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("sqrt done without work");

  property p_done_pulse;
    @(posedge clk_i) disable iff (!rst_ni) done_q |=> !done_q;
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("sqrt done held");

  property p_mask_onehot;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> $onehot(mask_q);
  endproperty
  a_mask_onehot: assert property (p_mask_onehot) else $error("sqrt mask not one-hot");

endmodule

// ===== rtl/canny_edge_detector_3x3.sv =====
// 3x3 canny edge detector: blur, sobel, suppression, thresholds, hysteresis
// one packed ring memory of four rows plus a two-row edge memory
// depends on ced_pkg and ced_sqrt
//
// Pixels come in raster order, one item each, and every item returns the
// edge bit of the pixel 4*(W+1) raster positions back once the pipeline has
// filled; after the last pixel of a frame, send flush items to drain the
// remaining results, the last one flagged last_of_frame. A new item
// is accepted only once the last one is done: each of the four stages
// reads its 3x3 neighborhood one word per cycle from the single read port of
// the row memory, and the gradient stage adds an eight-step square root. Stages
// that have no pixel yet (frame fill) are skipped through the step, check
// and advance states. No clearing pass runs after reset. Width and height
// are taken at the first pixel of a frame; thresholds and weights act at once.
module canny_edge_detector_3x3
  import ced_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ced_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ced_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = CW + 1;
  localparam int AW     = CW + 2;
  localparam int FAW    = CW + 1;
  localparam int DEPTH  = 4 << CW;
  localparam int FDEPTH = 2 << CW;
  localparam int PW     = ROW_W + 1;

  typedef struct packed {
    logic raw;
    logic blur;
    logic md;
    logic cls;
    logic fin;
  } mem_wr_t;

  // configuration
  logic [ROW_W-1:0]  cfg_w_q, cfg_h_q;
  logic [PIX_W-1:0]  low_q, high_q;
  logic [WGT_W-1:0]  wc_q, ws_q, wk_q;

  // frame and sequencing
  ced_state_e            state_q, state_d;
  logic [WW-1:0]         cur_w_q, eff_w;
  logic [ROW_W-1:0]      cur_h_q, eff_h;
  logic [ROW_W-1:0]      row_q;
  logic [CW-1:0]         col_q;
  ced_in_t               in_q;
  logic [1:0]            stage_q;
  logic signed [PW-1:0]  pos_r_q, nxt_r;
  logic [CW-1:0]         pos_c_q, nxt_c;
  logic [TAP_W-1:0]      tap_q;
  logic                  rd_pend_q;
  logic [TAP_W-1:0]      rd_idx_q;
  ced_word_t             win_q [NTAP];
  logic                  fin_win_q [NTAP];
  logic [ACC_W-1:0]      acc_q;
  logic [PIX_W-1:0]      gx_q, gy_q;
  logic [15:0]           gxx_q, gyy_q, s2_q;
  logic [17:0]           s1_q;
  logic                  res_q, res_last_q, res_vld_q;
  logic                  out_valid_q;
  ced_out_t              out_q;

  // memories
  ced_word_t mem_q [DEPTH];
  logic      fin_mem_q [FDEPTH];
  ced_word_t mem_rd_q;
  logic      fin_rd_q;

  // datapath signals
  logic                  accept, frame_start, idle_flush, pos_ok, border, pos_last;
  logic                  out_ok, col_wrap;
  logic [ROW_W-1:0]      pr;
  logic signed [PW-1:0]  dr;
  logic [CW-1:0]         dc;
  logic signed [PW-1:0]  ta_r;
  logic [CW-1:0]         ta_c;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [FAW-1:0]        fin_rd_addr, fin_wr_addr;
  mem_wr_t               wr;
  logic [PIX_W-1:0]      raw_d, blur_d, mag_d;
  logic [1:0]            dir_d, cls_d, dir_calc;
  logic                  fin_d;
  logic [WGT_W-1:0]      tap_w;
  logic [PIX_W-1:0]      gx_d, gy_d, sup_a, sup_b, sup_s, gdiff;
  logic [8:0]            gsum;
  logic                  sq_start, sq_done;
  logic [ROOT_W-1:0]     sq_root;

  function automatic logic signed [10:0] ext8(input logic [PIX_W-1:0] v);
    return $signed({3'b000, v});
  endfunction

  function automatic logic [PIX_W-1:0] half_abs_sat(input logic signed [10:0] s);
    logic [10:0] a;
    logic [9:0]  h;
    a = s[10] ? 11'(-s) : 11'(s);
    h = a[10:1];
    return (h > 10'd255) ? 8'hFF : h[PIX_W-1:0];
  endfunction

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 11'd512;
      cfg_h_q <= 11'd512;
      low_q   <= 8'd10;
      high_q  <= 8'd30;
      wc_q    <= 16'd10430;
      ws_q    <= 16'd6326;
      wk_q    <= 16'd3837;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:   cfg_w_q <= cfg_data_i[ROW_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_h_q <= cfg_data_i[ROW_W-1:0];
        REG_LOW_THRESH:    low_q   <= cfg_data_i[PIX_W-1:0];
        REG_HIGH_THRESH:   high_q  <= cfg_data_i[PIX_W-1:0];
        REG_WEIGHT_CENTER: wc_q    <= cfg_data_i;
        REG_WEIGHT_SIDE:   ws_q    <= cfg_data_i;
        REG_WEIGHT_CORNER: wk_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_w_q < 11'd3) begin
      eff_w = WW'(3);
    end else if (int'(cfg_w_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_w_q);
    end
    if (cfg_h_q < 11'd3) begin
      eff_h = ROW_W'(3);
    end else if (int'(cfg_h_q) > HGT_MAX) begin
      eff_h = ROW_W'(HGT_MAX);
    end else begin
      eff_h = cfg_h_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign frame_start = (row_q == '0) && (col_q == '0);
  assign idle_flush  = frame_start && in_data_i.flush;
  assign out_ok      = !out_valid_q || !out_stall_i;
  assign col_wrap    = (WW'(col_q) + WW'(1)) >= cur_w_q;

  // position of the current stage
  assign pr       = pos_r_q[ROW_W-1:0];
  assign pos_ok   = !pos_r_q[PW-1] && (pr < cur_h_q);
  assign border   = (pr == '0) || (pos_c_q == '0) || ((pr + ROW_W'(1)) >= cur_h_q)
                    || ((WW'(pos_c_q) + WW'(1)) >= cur_w_q);
  assign pos_last = (pr == cur_h_q - ROW_W'(1)) && (WW'(pos_c_q) == cur_w_q - WW'(1));

  always_comb begin
    if (pos_c_q == '0) begin
      nxt_c = CW'(cur_w_q - WW'(1));
      nxt_r = pos_r_q - PW'(2);
    end else begin
      nxt_c = pos_c_q - CW'(1);
      nxt_r = pos_r_q - PW'(1);
    end
  end

  // neighborhood tap offsets
  always_comb begin
    unique case (tap_q)
      4'd0, 4'd1, 4'd2: dr = -PW'(1);
      4'd3, 4'd4, 4'd5: dr = '0;
      default:          dr = PW'(1);
    endcase
    unique case (tap_q)
      4'd0, 4'd3, 4'd6: dc = '1;
      4'd1, 4'd4, 4'd7: dc = '0;
      default:          dc = CW'(1);
    endcase
  end

  assign ta_r        = pos_r_q + dr;
  assign ta_c        = pos_c_q + dc;
  assign rd_addr     = {ta_r[1:0], ta_c};
  assign fin_rd_addr = {ta_r[0], ta_c};
  assign fin_wr_addr = {pos_r_q[0], pos_c_q};
  assign wr_addr     = (state_q == S_RAW) ? {row_q[1:0], col_q} : {pos_r_q[1:0], pos_c_q};

  always_comb begin
    unique case (rd_idx_q)
      4'd0, 4'd2, 4'd6, 4'd8: tap_w = wk_q;
      TAP_CENTER:             tap_w = wc_q;
      default:                tap_w = ws_q;
    endcase
  end

  // stage arithmetic
  assign raw_d = in_q.flush ? '0 : in_q.pixel;

  always_comb begin
    if (border) begin
      blur_d = win_q[TAP_CENTER].raw;
    end else if (|acc_q[ACC_W-1:24]) begin
      blur_d = 8'hFF;
    end else begin
      blur_d = acc_q[23:16];
    end
  end

  assign gx_d = half_abs_sat((ext8(win_q[2].blur) - ext8(win_q[0].blur))
                 + ((ext8(win_q[5].blur) - ext8(win_q[3].blur)) <<< 1)
                 + (ext8(win_q[8].blur) - ext8(win_q[6].blur)));
  assign gy_d = half_abs_sat((ext8(win_q[6].blur) - ext8(win_q[0].blur))
                 + ((ext8(win_q[7].blur) - ext8(win_q[1].blur)) <<< 1)
                 + (ext8(win_q[8].blur) - ext8(win_q[2].blur)));
  assign gsum  = 9'(gx_q) + 9'(gy_q);
  assign gdiff = (gy_q > gx_q) ? gy_q - gx_q : '0;

  always_comb begin
    if (((gx_q == '0) && (gy_q == '0)) || (s1_q < {1'b0, gxx_q, 1'b0})) begin
      dir_calc = DIR_0;
    end else if ((gy_q <= gx_q) || ({1'b0, s2_q} < {gxx_q, 1'b0})) begin
      dir_calc = DIR_45;
    end else begin
      dir_calc = DIR_90;
    end
    mag_d = border ? '0 : sq_root;
    dir_d = border ? DIR_0 : dir_calc;
  end

  always_comb begin
    unique case (win_q[TAP_CENTER].dir)
      DIR_0: begin
        sup_a = win_q[5].mag;
        sup_b = win_q[3].mag;
      end
      DIR_45: begin
        sup_a = win_q[6].mag;
        sup_b = win_q[2].mag;
      end
      default: begin
        sup_a = win_q[7].mag;
        sup_b = win_q[1].mag;
      end
    endcase
    sup_s = ((win_q[TAP_CENTER].mag >= sup_a) && (win_q[TAP_CENTER].mag >= sup_b))
            ? win_q[TAP_CENTER].mag : '0;
    priority if (border) begin
      cls_d = CLS_NONE;
    end else if (sup_s < low_q) begin
      cls_d = CLS_NONE;
    end else if (sup_s > high_q) begin
      cls_d = CLS_STRONG;
    end else if ((sup_s > low_q) && (sup_s < high_q)) begin
      cls_d = CLS_WEAK;
    end else begin
      cls_d = CLS_NONE;
    end
  end

  always_comb begin
    fin_d = 1'b0;
    if (!border) begin
      if (win_q[TAP_CENTER].cls == CLS_STRONG) begin
        fin_d = 1'b1;
      end else if (win_q[TAP_CENTER].cls == CLS_WEAK) begin
        fin_d = fin_win_q[0] || fin_win_q[1] || fin_win_q[2] || fin_win_q[3]
                || (win_q[5].cls == CLS_STRONG) || (win_q[6].cls == CLS_STRONG)
                || (win_q[7].cls == CLS_STRONG) || (win_q[8].cls == CLS_STRONG);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && !idle_flush) state_d = S_RAW;
      S_RAW:   state_d = S_STEP;
      S_STEP:  state_d = S_CHECK;
      S_CHECK: state_d = pos_ok ? S_TAP : S_ADV;
      S_TAP:   if (tap_q == TAP_LAST) state_d = S_DRAIN;
      S_DRAIN: state_d = S_EVAL;
      S_EVAL:  state_d = ((stage_q == 2'd1) && !border) ? S_GSQ : S_ADV;
      S_GSQ:   state_d = S_SQST;
      S_SQST:  state_d = S_SQRT;
      S_SQRT:  if (sq_done) state_d = S_GWB;
      S_GWB:   state_d = S_ADV;
      S_ADV:   state_d = (stage_q == 2'd3) ? S_DONE : S_STEP;
      S_DONE:  if (!res_vld_q || out_ok) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    wr       = '0;
    sq_start = 1'b0;
    unique case (state_q)
      S_RAW:  wr.raw = (row_q < cur_h_q);
      S_EVAL: begin
        unique case (stage_q)
          2'd0:    wr.blur = 1'b1;
          2'd1:    wr.md   = border;
          2'd2:    wr.cls  = 1'b1;
          default: wr.fin  = 1'b1;
        endcase
      end
      S_SQST: sq_start = 1'b1;
      S_GWB:  wr.md = 1'b1;
      default: ;
    endcase
  end

  ced_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (RAD_W'(gxx_q) + RAD_W'(gyy_q)),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // memories
  always_ff @(posedge clk_i) begin
    if (wr.raw) mem_q[wr_addr].raw <= raw_d;
    if (wr.blur) mem_q[wr_addr].blur <= blur_d;
    if (wr.md) begin
      mem_q[wr_addr].mag <= mag_d;
      mem_q[wr_addr].dir <= dir_d;
    end
    if (wr.cls) mem_q[wr_addr].cls <= cls_d;
    mem_rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr.fin) fin_mem_q[fin_wr_addr] <= fin_d;
    fin_rd_q <= fin_mem_q[fin_rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      cur_w_q     <= WW'(512 > MAX_WIDTH ? MAX_WIDTH : 512);
      cur_h_q     <= 11'd512;
      stage_q     <= '0;
      tap_q       <= '0;
      rd_pend_q   <= 1'b0;
      res_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == S_TAP);
      if (accept && frame_start && !in_data_i.flush) begin
        cur_w_q <= eff_w;
        cur_h_q <= eff_h;
      end
      if (state_q == S_RAW) begin
        stage_q   <= '0;
        res_vld_q <= 1'b0;
      end
      if (state_q == S_CHECK) tap_q <= '0;
      if (state_q == S_TAP) tap_q <= tap_q + TAP_W'(1);
      if ((state_q == S_ADV) && (stage_q != 2'd3)) stage_q <= stage_q + 2'd1;
      if ((state_q == S_EVAL) && (stage_q == 2'd3)) res_vld_q <= 1'b1;
      if ((state_q == S_DONE) && (!res_vld_q || out_ok)) begin
        if (res_vld_q && res_last_q) begin
          row_q <= '0;
          col_q <= '0;
        end else if (col_wrap) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if ((state_q == S_DONE) && res_vld_q && out_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    if (state_q == S_RAW) begin
      pos_r_q <= PW'(row_q);
      pos_c_q <= col_q;
    end
    if (state_q == S_STEP) begin
      pos_r_q <= nxt_r;
      pos_c_q <= nxt_c;
    end
    if (state_q == S_CHECK) acc_q <= '0;
    if (rd_pend_q) begin
      win_q[rd_idx_q]     <= mem_rd_q;
      fin_win_q[rd_idx_q] <= fin_rd_q;
      acc_q <= acc_q + ACC_W'(tap_w) * ACC_W'(mem_rd_q.raw);
    end
    rd_idx_q <= tap_q;
    if ((state_q == S_EVAL) && (stage_q == 2'd1)) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
    if (state_q == S_GSQ) begin
      gxx_q <= 16'(gx_q) * 16'(gx_q);
      gyy_q <= 16'(gy_q) * 16'(gy_q);
      s1_q  <= 18'(gsum) * 18'(gsum);
      s2_q  <= 16'(gdiff) * 16'(gdiff);
    end
    if ((state_q == S_EVAL) && (stage_q == 2'd3)) begin
      res_q      <= fin_d;
      res_last_q <= pos_last;
    end
    if ((state_q == S_DONE) && res_vld_q && out_ok) begin
      out_q.edge_res      <= res_q;
      out_q.last_of_frame <= res_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  property p_out_from_done;
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> ($past(state_q) == S_DONE);
  endproperty
  a_out_from_done: assert property (p_out_from_done) else $error("item shown outside done");

  property p_last_restarts;
    @(posedge clk_i) disable iff (!rst_ni)
      ($rose(out_valid_q) && out_q.last_of_frame) |-> (row_q == '0 && col_q == '0);
  endproperty
  a_last_restarts: assert property (p_last_restarts) else $error("frame end left counters");

  property p_tap_in_frame;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_TAP) |-> pos_ok;
  endproperty
  a_tap_in_frame: assert property (p_tap_in_frame) else $error("stage read outside frame");

  property p_sqrt_done_waited;
    @(posedge clk_i) disable iff (!rst_ni) sq_done |-> (state_q == S_SQRT);
  endproperty
  a_sqrt_done_waited: assert property (p_sqrt_done_waited) else $error("root not awaited");

endmodule
